// ===== hdl/binary_lifting_lca_top_assert.svh =====
// assertion macros shared by the lca checker
`ifndef BINARY_LIFTING_LCA_TOP_ASSERT_SVH
`define BINARY_LIFTING_LCA_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BLCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/blca_pkg.sv =====
// types and constants for the binary lifting lca block
`timescale 1ns / 1ps

package blca_pkg;

  localparam int NODE_W     = 10;
  localparam int DEPTH_W    = 10;
  localparam int DIST_W     = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - NODE_W - DIST_W - DEPTH_W;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 11'd2046;

  localparam logic FUNC_ATTACH = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AT_DEP,
    ST_AT_SAVE,
    ST_AT_LIFT,
    ST_Q_DEP,
    ST_Q_ORDER,
    ST_Q_UP,
    ST_Q_MEET,
    ST_Q_JUMP,
    ST_Q_ROOT,
    ST_Q_DIST,
    ST_PUSH
  } blca_state_t;

endpackage

// ===== hdl/blca_ram.sv =====
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps

module blca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                       rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// ===== hdl/binary_lifting_lca_top.sv =====
// Lowest common ancestor by binary lifting, root is node 0.
// Input channel in_*: in_tuser selects the request (attach or query), in_tdata carries
// the two node numbers. An attach hangs node under other_node and returns the child's
// depth; a query returns the lowest common ancestor of both nodes and their distance.
// Result channel out_*: one result per request, held in an output register.
// Ancestor table and depths live in two rams with registered reads; each lifting
// level costs one table read, and the next read address comes straight from the
// returned data. The next request is taken in the cycle after the result is loaded.
// Only one request is in flight at a time.
// After reset a clearing pass writes zero to every ram entry, one per cycle;
// in_tready stays low during the pass.
// If out_tready is low, a finished result waits in the block until the output register
// frees up; no further request is accepted meanwhile.
`timescale 1ns / 1ps

module binary_lifting_lca_top
  import blca_pkg::*;
#(
  parameter int NODE_COUNT  = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // node [9:0], other_node [19:10], zero pad
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // common_ancestor [9:0],
                                            // tree_distance [20:10],
                                            // attached_depth [30:21], zero pad
);

  localparam int ND        = (NODE_COUNT < (1 << NODE_W)) ? NODE_COUNT : (1 << NODE_W);
  localparam int NIW       = $clog2(ND);
  localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int TAW       = NIW + LW;
  localparam int TBL_DEPTH = ND * (1 << LW);
  localparam logic [16:0] NODE_LIM = 17'(NODE_COUNT);
  localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);

  function automatic logic [TAW-1:0] taddr(input logic [NODE_W-1:0] n,
                                           input logic [LW-1:0] l);
    return {n[NIW-1:0], l};
  endfunction

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return ({7'd0, n} < NODE_LIM);
  endfunction

  blca_state_t state_r, state_nxt;

  logic [NODE_W-1:0]      a_r, a_nxt;
  logic [NODE_W-1:0]      b_r, b_nxt;
  logic [DEPTH_W-1:0]     da_r, da_nxt;
  logic [DEPTH_W-1:0]     db_r, db_nxt;
  logic [LIFT_LEVELS-1:0] gap_r, gap_nxt;
  logic [LW-1:0]          lvl_r, lvl_nxt;
  logic                   pend_r, pend_nxt;
  logic [NODE_W-1:0]      res_lca_r, res_lca_nxt;
  logic [DIST_W-1:0]      res_dist_r, res_dist_nxt;
  logic [DEPTH_W-1:0]     res_dep_r, res_dep_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [TAW-1:0]         clr_r, clr_nxt;
  logic                   fwd_hit_r, fwd_hit_nxt;
  logic [NODE_W-1:0]      fwd_data_r, fwd_data_nxt;

  logic                tbl_we;
  logic [TAW-1:0]      tbl_waddr, tbl_raddr_a, tbl_raddr_b;
  logic [NODE_W-1:0]   tbl_wdata, tbl_rdata_a, tbl_rdata_b, tbl_qa;
  logic                dep_we;
  logic [NIW-1:0]      dep_waddr, dep_raddr_a, dep_raddr_b;
  logic [DEPTH_W-1:0]  dep_wdata, dep_rdata_a, dep_rdata_b;

  logic [NODE_W-1:0]   in_node, in_other;
  logic [NODE_W-1:0]   a_cur, na, nb;
  logic [DEPTH_W-1:0]  gap_full, dnew;
  logic [DIST_W-1:0]   dsum, dtwice, ddiff;
  logic [LIFT_LEVELS+DEPTH_W-1:0] gap_ext;

  assign in_node  = in_tdata[NODE_W-1:0];
  assign in_other = in_tdata[2*NODE_W-1:NODE_W];

  // a table write and a read of the same entry in one cycle: take the written value
  assign tbl_qa = fwd_hit_r ? fwd_data_r : tbl_rdata_a;

  blca_ram #(.WIDTH(NODE_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .raddr_a (tbl_raddr_a),
    .rdata_a (tbl_rdata_a),
    .raddr_b (tbl_raddr_b),
    .rdata_b (tbl_rdata_b)
  );

  blca_ram #(.WIDTH(DEPTH_W), .DEPTH(ND)) u_dep_ram (
    .clk     (clk),
    .we      (dep_we),
    .waddr   (dep_waddr),
    .wdata   (dep_wdata),
    .raddr_a (dep_raddr_a),
    .rdata_a (dep_rdata_a),
    .raddr_b (dep_raddr_b),
    .rdata_b (dep_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
      pend_r      <= 1'b0;
      lvl_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_hit_r   <= fwd_hit_nxt;
      pend_r      <= pend_nxt;
      lvl_r       <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    gap_r      <= gap_nxt;
    res_lca_r  <= res_lca_nxt;
    res_dist_r <= res_dist_nxt;
    res_dep_r  <= res_dep_nxt;
    out_data_r <= out_data_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    gap_nxt       = gap_r;
    lvl_nxt       = lvl_r;
    pend_nxt      = pend_r;
    res_lca_nxt   = res_lca_r;
    res_dist_nxt  = res_dist_r;
    res_dep_nxt   = res_dep_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    clr_nxt       = clr_r;

    tbl_we      = 1'b0;
    tbl_waddr   = '0;
    tbl_wdata   = '0;
    tbl_raddr_a = '0;
    tbl_raddr_b = '0;
    dep_we      = 1'b0;
    dep_waddr   = '0;
    dep_wdata   = '0;
    dep_raddr_a = '0;
    dep_raddr_b = '0;

    a_cur    = pend_r ? tbl_qa : a_r;
    na       = a_r;
    nb       = b_r;
    gap_full = '0;
    gap_ext  = '0;
    dnew     = '0;
    dsum     = '0;
    dtwice   = '0;
    ddiff    = '0;

    unique case (state_r)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        dep_we    = 1'b1;
        dep_waddr = clr_r[TAW-1:LW];
        clr_nxt   = clr_r + TAW'(1);
        if (clr_r == TAW'(TBL_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          res_lca_nxt  = '0;
          res_dist_nxt = '0;
          res_dep_nxt  = '0;
          a_nxt        = in_node;
          b_nxt        = in_other;
          if (in_tuser == FUNC_QUERY) begin
            // out of range nodes stand for the root
            if (!node_ok(in_node)) begin
              a_nxt = '0;
            end
            if (!node_ok(in_other)) begin
              b_nxt = '0;
            end
            state_nxt = ST_Q_DEP;
          end else if (in_node == '0 || !node_ok(in_node) || !node_ok(in_other)) begin
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_AT_DEP;
          end
        end
      end
      ST_AT_DEP: begin
        dep_raddr_a = b_r[NIW-1:0];
        tbl_we      = 1'b1;
        tbl_waddr   = taddr(a_r, '0);
        tbl_wdata   = b_r;
        state_nxt   = ST_AT_SAVE;
      end
      ST_AT_SAVE: begin
        dnew        = (dep_rdata_a >= DEPTH_MAX) ? DEPTH_MAX : dep_rdata_a + DEPTH_W'(1);
        dep_we      = 1'b1;
        dep_waddr   = a_r[NIW-1:0];
        dep_wdata   = dnew;
        res_dep_nxt = dnew;
        if (LIFT_LEVELS == 1) begin
          state_nxt = ST_PUSH;
        end else begin
          // parent's level 0 is the child's level 1
          tbl_raddr_a = taddr(b_r, '0);
          lvl_nxt     = LW'(1);
          state_nxt   = ST_AT_LIFT;
        end
      end
      ST_AT_LIFT: begin
        tbl_we    = 1'b1;
        tbl_waddr = taddr(a_r, lvl_r);
        tbl_wdata = tbl_qa;
        if (lvl_r == LVL_TOP) begin
          state_nxt = ST_PUSH;
        end else begin
          tbl_raddr_a = taddr(tbl_qa, lvl_r);
          lvl_nxt     = lvl_r + LW'(1);
        end
      end
      ST_Q_DEP: begin
        dep_raddr_a = a_r[NIW-1:0];
        dep_raddr_b = b_r[NIW-1:0];
        state_nxt   = ST_Q_ORDER;
      end
      ST_Q_ORDER: begin
        da_nxt = dep_rdata_a;
        db_nxt = dep_rdata_b;
        if (dep_rdata_a < dep_rdata_b) begin
          a_nxt    = b_r;
          b_nxt    = a_r;
          gap_full = dep_rdata_b - dep_rdata_a;
        end else begin
          gap_full = dep_rdata_a - dep_rdata_b;
        end
        // only the low LIFT_LEVELS bits of the gap can be lifted
        gap_ext   = {{LIFT_LEVELS{1'b0}}, gap_full};
        gap_nxt   = gap_ext[LIFT_LEVELS-1:0];
        lvl_nxt   = LVL_TOP;
        pend_nxt  = 1'b0;
        state_nxt = ST_Q_UP;
      end
      ST_Q_UP: begin
        a_nxt = a_cur;
        if (gap_r[LIFT_LEVELS-1]) begin
          tbl_raddr_a = taddr(a_cur, lvl_r);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        gap_nxt = gap_r << 1;
        if (lvl_r == '0) begin
          state_nxt = ST_Q_MEET;
        end else begin
          lvl_nxt = lvl_r - LW'(1);
        end
      end
      ST_Q_MEET: begin
        a_nxt    = a_cur;
        pend_nxt = 1'b0;
        if (a_cur == b_r) begin
          res_lca_nxt = a_cur;
          dep_raddr_a = a_cur[NIW-1:0];
          state_nxt   = ST_Q_DIST;
        end else begin
          tbl_raddr_a = taddr(a_cur, LVL_TOP);
          tbl_raddr_b = taddr(b_r, LVL_TOP);
          lvl_nxt     = LVL_TOP;
          state_nxt   = ST_Q_JUMP;
        end
      end
      ST_Q_JUMP: begin
        if (tbl_qa != tbl_rdata_b) begin
          na = tbl_qa;
          nb = tbl_rdata_b;
        end
        a_nxt = na;
        b_nxt = nb;
        if (lvl_r == '0) begin
          tbl_raddr_a = taddr(na, '0);
          state_nxt   = ST_Q_ROOT;
        end else begin
          tbl_raddr_a = taddr(na, lvl_r - LW'(1));
          tbl_raddr_b = taddr(nb, lvl_r - LW'(1));
          lvl_nxt     = lvl_r - LW'(1);
        end
      end
      ST_Q_ROOT: begin
        res_lca_nxt = tbl_qa;
        dep_raddr_a = tbl_qa[NIW-1:0];
        state_nxt   = ST_Q_DIST;
      end
      ST_Q_DIST: begin
        dsum   = {1'b0, da_r} + {1'b0, db_r};
        dtwice = {dep_rdata_a, 1'b0};
        // out of order attaches can make this negative
        ddiff  = (dsum < dtwice) ? '0 : dsum - dtwice;
        res_dist_nxt = (ddiff > DIST_MAX) ? DIST_MAX : ddiff;
        state_nxt    = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, res_dep_r, res_dist_r, res_lca_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    fwd_hit_nxt  = tbl_we && (tbl_waddr == tbl_raddr_a);
    fwd_data_nxt = tbl_wdata;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/blca_chk.sv =====
// port-level checker for the lca block, bound to the top level
`timescale 1ns / 1ps
`include "binary_lifting_lca_top_assert.svh"

module blca_chk
  import blca_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result keeps its value
  `BLCA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "stalled result changed")

  // one request at a time: no acceptance right after one
  `BLCA_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready,
                    !in_tready, "request accepted while one is in flight")

  // an attach result carries no ancestor and no distance
  `BLCA_ASSERT_NOW(a_attach_clean, out_tvalid && out_tdata[30:21] != 10'd0,
                   out_tdata[20:0] == 21'd0, "attach result has query fields set")

  // distance never exceeds the largest possible path
  `BLCA_ASSERT_NOW(a_dist_range, out_tvalid,
                   out_tdata[20:10] <= DIST_MAX, "distance out of range")

endmodule

bind binary_lifting_lca_top blca_chk u_blca_chk (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// self-checking testbench for the binary lifting lowest common ancestor block
module tb;
  import blca_pkg::*;

  localparam int NODES  = 1024;
  localparam int LEVELS = 10;
  localparam int CHAIN  = 400;

  // same bit order as out_tdata: common_ancestor in the low bits
  typedef struct packed {
    logic [DEPTH_W-1:0] attached_depth;
    logic [DIST_W-1:0]  tree_distance;
    logic [NODE_W-1:0]  common_ancestor;
  } answer_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = FUNC_ATTACH;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [NODE_W-1:0]  lift_table [NODES][LEVELS];
  logic [DEPTH_W-1:0] depth_of [NODES];
  answer_t            pending_answers [$];
  int                 mismatches     = 0;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 hold_off_left  = 0;

  binary_lifting_lca_top #(
    .NODE_COUNT (NODES),
    .LIFT_LEVELS(LEVELS)
  ) u_top (.*);

  always #10 clk = ~clk;

  function automatic logic [NODE_W-1:0] common_ancestor_of(input logic [NODE_W-1:0] a,
                                                          input logic [NODE_W-1:0] b);
    logic [NODE_W-1:0]  swap, up_a, up_b;
    logic [DEPTH_W-1:0] gap;
    if (depth_of[a] < depth_of[b]) begin
      swap = a;
      a = b;
      b = swap;
    end
    gap = depth_of[a] - depth_of[b];
    for (int i = LEVELS - 1; i >= 0; i--)
      if (gap[i]) a = lift_table[a][i];
    if (a == b) return a;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      up_a = lift_table[a][i];
      up_b = lift_table[b][i];
      if (up_a != up_b) begin
        a = up_a;
        b = up_b;
      end
    end
    return lift_table[a][0];
  endfunction

  // updates the tree copy and returns the answer the block should give
  function automatic answer_t answer_for(input logic func, input logic [NODE_W-1:0] node,
                                         input logic [NODE_W-1:0] other);
    answer_t           ans;
    logic [NODE_W-1:0] meet;
    int                span;
    ans = '0;
    if (func == FUNC_ATTACH) begin
      // attaching the root is ignored
      if (node != '0) begin
        ans.attached_depth = (depth_of[other] >= DEPTH_MAX) ? DEPTH_MAX
                                                            : depth_of[other] + 1'b1;
        depth_of[node] = ans.attached_depth;
        lift_table[node][0] = other;
        for (int j = 1; j < LEVELS; j++)
          lift_table[node][j] = lift_table[lift_table[node][j-1]][j-1];
      end
    end else begin
      meet = common_ancestor_of(node, other);
      span = int'(depth_of[node]) + int'(depth_of[other]) - 2 * int'(depth_of[meet]);
      if (span < 0) span = 0;
      if (span > int'(DIST_MAX)) span = int'(DIST_MAX);
      ans.common_ancestor = meet;
      ans.tree_distance   = span[DIST_W-1:0];
    end
    return ans;
  endfunction

  task automatic send_request(input logic func, input logic [NODE_W-1:0] node,
                              input logic [NODE_W-1:0] other);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{(IN_DATA_W - 2 * NODE_W){1'b0}}, other, node};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_answers.insert(pending_answers.size(), answer_for(func, node, other));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(FUNC_QUERY, 10'd0, 10'd0);
    send_request(FUNC_ATTACH, 10'd0, 10'd5);       // root attach, ignored
    send_request(FUNC_ATTACH, 10'd1, 10'd0);
    send_request(FUNC_ATTACH, 10'd2, 10'd1);
    send_request(FUNC_ATTACH, 10'd3, 10'd1);
    send_request(FUNC_ATTACH, 10'd4, 10'd2);
    send_request(FUNC_QUERY, 10'd4, 10'd3);
    send_request(FUNC_QUERY, 10'd3, 10'd4);
    send_request(FUNC_QUERY, 10'd4, 10'd4);
    send_request(FUNC_QUERY, 10'd4, 10'd0);
    send_request(FUNC_QUERY, 10'd1023, 10'd4);     // never attached node
    send_request(FUNC_ATTACH, 10'd1023, 10'd4);
    send_request(FUNC_QUERY, 10'd1023, 10'd3);
    send_request(FUNC_ATTACH, 10'd1022, 10'd1022); // self attach of a loose node
    send_request(FUNC_QUERY, 10'd1022, 10'd1023);
    send_request(FUNC_ATTACH, 10'd7, 10'd600);     // parent never attached
    send_request(FUNC_ATTACH, 10'd2, 10'd4);       // out of order, makes a loop
    send_request(FUNC_QUERY, 10'd4, 10'd3);
    send_request(FUNC_QUERY, 10'd2, 10'd1023);
    send_request(FUNC_QUERY, 10'd1023, 10'd1022);
    send_request(FUNC_QUERY, 10'd7, 10'd1);
    stop_sending();
  endtask

  // one long path from the root: large depth gaps across many lifting levels
  task automatic test_deep_chain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int k = 1; k <= CHAIN; k++)
      send_request(FUNC_ATTACH, NODE_W'(k), NODE_W'(k - 1));
    send_request(FUNC_QUERY, NODE_W'(CHAIN), 10'd1);
    send_request(FUNC_QUERY, 10'd1, NODE_W'(CHAIN));
    send_request(FUNC_QUERY, NODE_W'(CHAIN), 10'd0);
    send_request(FUNC_QUERY, 10'd380, 10'd130);
    send_request(FUNC_QUERY, NODE_W'(CHAIN), NODE_W'(CHAIN - 1));
    for (int i = 0; i < 10; i++)
      send_request(FUNC_QUERY, NODE_W'($urandom), NODE_W'($urandom));
    send_request(FUNC_ATTACH, NODE_W'(CHAIN), NODE_W'(CHAIN));
    send_request(FUNC_ATTACH, 10'd1, NODE_W'(CHAIN));
    send_request(FUNC_QUERY, 10'd1, 10'd2);
    send_request(FUNC_QUERY, NODE_W'(CHAIN), 10'd600);
    stop_sending();
  endtask

  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int recv_pct);
    logic [NODE_W-1:0] grown [$];
    logic [NODE_W-1:0] child, parent, first, second;
    int                roll;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    grown.insert(grown.size(), NODE_W'(0));
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        // grow the tree under a known node, often the newest to get depth
        child  = NODE_W'($urandom_range(NODES - 1, 1));
        parent = ($urandom_range(1) == 1) ? grown[$]
                                          : grown[$urandom_range(grown.size() - 1)];
        send_request(FUNC_ATTACH, child, parent);
        grown.insert(grown.size(), child);
      end else if (roll < 85) begin
        first  = grown[$urandom_range(grown.size() - 1)];
        second = ($urandom_range(3) == 0) ? NODE_W'($urandom)
                                          : grown[$urandom_range(grown.size() - 1)];
        send_request(FUNC_QUERY, first, second);
      end else begin
        // noise: any fields, may reparent or break the tree
        send_request(1'($urandom_range(1)), NODE_W'($urandom), NODE_W'($urandom));
      end
    end
    stop_sending();
  endtask

  // receiver holds off long enough that the input side stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 600;
    for (int i = 0; i < 12; i++)
      send_request((i % 2 == 0) ? FUNC_ATTACH : FUNC_QUERY,
                   NODE_W'($urandom_range(NODES - 1, 1)), NODE_W'($urandom));
    stop_sending();
  endtask

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_answers
    answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(answer_t)-1:0];
      if (pending_answers.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (got.common_ancestor !== want.common_ancestor) begin
          $error("common_ancestor: expected %0d, got %0d",
                 want.common_ancestor, got.common_ancestor);
          mismatches++;
        end
        if (got.tree_distance !== want.tree_distance) begin
          $error("tree_distance: expected %0d, got %0d",
                 want.tree_distance, got.tree_distance);
          mismatches++;
        end
        if (got.attached_depth !== want.attached_depth) begin
          $error("attached_depth: expected %0d, got %0d",
                 want.attached_depth, got.attached_depth);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int n = 0; n < NODES; n++) begin
      depth_of[n] = '0;
      for (int l = 0; l < LEVELS; l++) lift_table[n][l] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_deep_chain();
    test_random_traffic(60, 0, 0);
    test_random_traffic(60, 76, 0);
    test_random_traffic(60, 0, 76);
    test_random_traffic(60, 33, 33);
    test_backpressure();
    wait (pending_answers.size() == 0);
    // catch any stray result after the last one
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, far above a slow but correct run including the clearing pass
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
